// ===== rtl/core/qrn_pkg.sv =====
// ----------------------------------------------------------------------------
// qrn_pkg
// Shared types and constants of the quaternion rotate and normalize core.
// ----------------------------------------------------------------------------
package qrn_pkg;

  // normalized magnitudes carry their leading one at this bit
  localparam int NORM_TOP  = 29;
  localparam int NORM_W    = NORM_TOP + 1;
  // sum of four squared normalized magnitudes, and its integer root
  localparam int SQ_W      = 2 * NORM_W + 2;
  localparam int ROOT_W    = SQ_W / 2;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W = 4'd0,
    REG_ROT_X = 4'd1,
    REG_ROT_Y = 4'd2,
    REG_ROT_Z = 4'd3
  } cfg_reg_t;

  // per-word control that rides along the pipeline
  typedef struct packed {
    logic       vld;
    logic       sel;
    logic       last;
    logic       zero;
    logic [3:0] neg;
  } qrn_ctl_t;

endpackage

// ===== rtl/core/qrn_ham.sv =====
// ----------------------------------------------------------------------------
// qrn_ham
// Hamilton product q * p: sixteen registered products, rounding, then sums.
// ----------------------------------------------------------------------------
module qrn_ham #(
  parameter int CB = 16,
  parameter int FB = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  qrn_pkg::qrn_ctl_t        ctl_i,
  input  logic [4*CB-1:0]          pass_i,  // p: w, x, y, z from the lowest bit
  input  logic [4*CB-1:0]          rot_i,   // q: w, x, y, z from the lowest bit
  output qrn_pkg::qrn_ctl_t        ctl_o,
  output logic [4*CB-1:0]          pass_o,
  output logic [4*(2*CB-FB+2)-1:0] r_o      // w, x, y, z from the lowest bit
);
  import qrn_pkg::*;

  localparam int PW2 = 2 * CB;
  localparam int RNW = 2 * CB - FB;
  localparam int RW  = RNW + 2;
  localparam logic [PW2-1:0] RBIAS = PW2'(1) << (FB - 1);

  logic signed [PW2-1:0] qe [4];
  logic signed [PW2-1:0] pe [4];
  logic signed [PW2-1:0] prod_r [4][4];
  logic [PW2-1:0]        rsum [4][4];
  logic [RNW-1:0]        rnd_r [4][4];
  logic signed [RW-1:0]  re [4][4];
  logic [RW-1:0]         r_r [4];

  qrn_ctl_t              ctl1_r, ctl2_r, ctl3_r;
  logic [4*CB-1:0]       pass1_r, pass2_r, pass3_r;

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      qe[a] = {{CB{rot_i[a*CB+CB-1]}}, rot_i[a*CB +: CB]};
      pe[a] = {{CB{pass_i[a*CB+CB-1]}}, pass_i[a*CB +: CB]};
      for (int b = 0; b < 4; b++) begin
        rsum[a][b] = prod_r[a][b] + RBIAS;
        re[a][b]   = {{2{rnd_r[a][b][RNW-1]}}, rnd_r[a][b]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // index 0..3 is w, x, y, z; first index q, second index p
  always_ff @(posedge clk) begin
    if (en) begin
      pass1_r <= pass_i;
      pass2_r <= pass1_r;
      pass3_r <= pass2_r;
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          prod_r[a][b] <= qe[a] * pe[b];
          // round half up: add half an LSB, keep the upper bits
          rnd_r[a][b]  <= rsum[a][b][PW2-1:FB];
        end
      end
      r_r[0] <= re[0][0] - re[1][1] - re[2][2] - re[3][3];
      r_r[1] <= re[0][1] + re[1][0] + re[2][3] - re[3][2];
      r_r[2] <= re[0][2] - re[1][3] + re[2][0] + re[3][1];
      r_r[3] <= re[0][3] + re[1][2] - re[2][1] + re[3][0];
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      r_o[a*RW +: RW] = r_r[a];
    end
  end

  assign ctl_o  = ctl3_r;
  assign pass_o = pass3_r;

endmodule

// ===== rtl/core/qrn_norm.sv =====
// ----------------------------------------------------------------------------
// qrn_norm
// Magnitudes, staged common left normalization, squares and their sum.
// ----------------------------------------------------------------------------
module qrn_norm #(
  parameter int CB = 16,
  parameter int FB = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  qrn_pkg::qrn_ctl_t            ctl_i,
  input  logic [4*CB-1:0]              pass_i,
  input  logic [4*(2*CB-FB+2)-1:0]     r_i,
  output qrn_pkg::qrn_ctl_t            ctl_o,
  output logic [4*CB-1:0]              pass_o,
  output logic [4*qrn_pkg::NORM_W-1:0] mag_o,  // w, x, y, z from the lowest bit
  output logic [qrn_pkg::SQ_W-1:0]     n_o
);
  import qrn_pkg::*;

  localparam int RW  = 2 * CB - FB + 2;
  localparam int MW  = RW - 1;
  localparam int PW  = (MW > NORM_W) ? MW : NORM_W;
  localparam int PAD = PW - MW;
  localparam int NST = $clog2(PW);

  logic [RW-1:0]         rl [4];
  logic [RW-1:0]         ra [4];
  logic [PW-1:0]         w0 [4];
  logic [PW-1:0]         or0;
  qrn_ctl_t              ctl0;

  logic [PW-1:0]         sh_r [0:NST][4];
  logic [PW-1:0]         or_r [0:NST];
  qrn_ctl_t              sc_r [0:NST];
  logic [4*CB-1:0]       sp_r [0:NST];

  logic [NORM_W-1:0]     top [4];
  logic [2*NORM_W-1:0]   sq_r [4];
  logic [NORM_W-1:0]     mq_r [4];
  qrn_ctl_t              cq_r;
  logic [4*CB-1:0]       pq_r;

  logic [SQ_W-1:0]       n_r;
  logic [NORM_W-1:0]     mn_r [4];
  qrn_ctl_t              cn_r;
  logic [4*CB-1:0]       pn_r;

  always_comb begin
    or0  = '0;
    ctl0 = ctl_i;
    for (int a = 0; a < 4; a++) begin
      rl[a] = r_i[a*RW +: RW];
      ra[a] = rl[a][RW-1] ? (RW'(0) - rl[a]) : rl[a];
      // park the magnitude at the top so one left normalization serves both
      // the up and down shift cases
      w0[a] = PW'(ra[a][MW-1:0]) << PAD;
      or0   = or0 | w0[a];
      ctl0.neg[a] = rl[a][RW-1];
    end
    ctl0.zero = (or0 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r[0] <= '0;
    end else if (en) begin
      sc_r[0] <= ctl0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r[0] <= pass_i;
      or_r[0] <= or0;
      for (int a = 0; a < 4; a++) begin
        sh_r[0][a] <= w0[a];
      end
    end
  end

  // one binary step of the leading-one search per stage, widest first
  for (genvar g = 1; g <= NST; g++) begin : g_shift
    localparam int AMT = 1 << (NST - g);
    logic hit;
    assign hit = (or_r[g-1][PW-1 -: AMT] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sc_r[g] <= '0;
      end else if (en) begin
        sc_r[g] <= sc_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[g] <= sp_r[g-1];
        or_r[g] <= hit ? (or_r[g-1] << AMT) : or_r[g-1];
        for (int a = 0; a < 4; a++) begin
          sh_r[g][a] <= hit ? (sh_r[g-1][a] << AMT) : sh_r[g-1][a];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      top[a] = sh_r[NST][a][PW-1 -: NORM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_r <= '0;
      cn_r <= '0;
    end else if (en) begin
      cq_r <= sc_r[NST];
      cn_r <= cq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq_r <= sp_r[NST];
      pn_r <= pq_r;
      for (int a = 0; a < 4; a++) begin
        sq_r[a] <= top[a] * top[a];
        mq_r[a] <= top[a];
        mn_r[a] <= mq_r[a];
      end
      n_r <= (SQ_W'(sq_r[0]) + SQ_W'(sq_r[1])) + (SQ_W'(sq_r[2]) + SQ_W'(sq_r[3]));
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      mag_o[a*NORM_W +: NORM_W] = mn_r[a];
    end
  end

  assign n_o    = n_r;
  assign ctl_o  = cn_r;
  assign pass_o = pn_r;

endmodule

// ===== rtl/core/qrn_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrn_sqrt #(
  parameter int CB = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  qrn_pkg::qrn_ctl_t            ctl_i,
  input  logic [4*CB-1:0]              pass_i,
  input  logic [4*qrn_pkg::NORM_W-1:0] mag_i,
  input  logic [qrn_pkg::SQ_W-1:0]     n_i,
  output qrn_pkg::qrn_ctl_t            ctl_o,
  output logic [4*CB-1:0]              pass_o,
  output logic [4*qrn_pkg::NORM_W-1:0] mag_o,
  output logic [qrn_pkg::ROOT_W-1:0]   root_o
);
  import qrn_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [SQ_W-1:0]     rad_r  [ROOT_W];
  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [4*NORM_W-1:0] m_r    [ROOT_W];
  logic [4*CB-1:0]     p_r    [ROOT_W];
  qrn_ctl_t            c_r    [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [SQ_W-1:0]     rad_s;
    logic [REM_W-1:0]    rem_s;
    logic [ROOT_W-1:0]   root_s;
    logic [4*NORM_W-1:0] mag_s;
    logic [4*CB-1:0]     pass_s;
    qrn_ctl_t            ctl_s;
    logic [REM_W-1:0]    rem_t;
    logic [REM_W-1:0]    trial;
    logic                ge;

    if (j == 0) begin : g_head
      assign rad_s  = n_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign mag_s  = mag_i;
      assign pass_s = pass_i;
      assign ctl_s  = ctl_i;
    end else begin : g_body
      assign rad_s  = rad_r[j-1];
      assign rem_s  = rem_r[j-1];
      assign root_s = root_r[j-1];
      assign mag_s  = m_r[j-1];
      assign pass_s = p_r[j-1];
      assign ctl_s  = c_r[j-1];
    end

    // bring down the next two radicand bits, try root bit one
    assign rem_t = {rem_s[REM_W-3:0], rad_s[SQ_W-1 -: 2]};
    assign trial = {root_s, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[j] <= '0;
      end else if (en) begin
        c_r[j] <= ctl_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= rad_s << 2;
        rem_r[j]  <= ge ? (rem_t - trial) : rem_t;
        root_r[j] <= {root_s[ROOT_W-2:0], ge};
        m_r[j]    <= mag_s;
        p_r[j]    <= pass_s;
      end
    end
  end

  assign ctl_o  = c_r[ROOT_W-1];
  assign pass_o = p_r[ROOT_W-1];
  assign mag_o  = m_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];

endmodule

// ===== rtl/core/qrn_div.sv =====
// ----------------------------------------------------------------------------
// qrn_div
// Four-lane pipelined restoring divider: rounded (m << FB) / S per lane.
// ----------------------------------------------------------------------------
module qrn_div #(
  parameter int CB = 16,
  parameter int FB = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  qrn_pkg::qrn_ctl_t            ctl_i,
  input  logic [4*CB-1:0]              pass_i,
  input  logic [4*qrn_pkg::NORM_W-1:0] mag_i,
  input  logic [qrn_pkg::ROOT_W-1:0]   root_i,
  output qrn_pkg::qrn_ctl_t            ctl_o,
  output logic [4*CB-1:0]              pass_o,
  output logic [4*(FB+1)-1:0]          q_o     // w, x, y, z from the lowest bit
);
  import qrn_pkg::*;

  localparam int QW = FB + 1;
  localparam int XW = NORM_W + FB + 1;

  logic [XW-1:0]     num_r [4];
  logic [ROOT_W-1:0] den_r;
  qrn_ctl_t          cp_r;
  logic [4*CB-1:0]   pp_r;

  logic [XW-1:0]     rem_r [QW][4];
  logic [QW-1:0]     q_r   [QW][4];
  logic [ROOT_W-1:0] d_r   [QW];
  qrn_ctl_t          c_r   [QW];
  logic [4*CB-1:0]   p_r   [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= '0;
    end else if (en) begin
      cp_r <= ctl_i;
    end
  end

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pass_i;
      den_r <= root_i;
      for (int a = 0; a < 4; a++) begin
        num_r[a] <= (XW'(mag_i[a*NORM_W +: NORM_W]) << FB) + XW'(root_i >> 1);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [XW-1:0]     rem_s [4];
    logic [QW-1:0]     q_s   [4];
    logic [ROOT_W-1:0] d_s;
    qrn_ctl_t          ctl_s;
    logic [4*CB-1:0]   pass_s;
    logic [XW-1:0]     dsh;
    logic [3:0]        ge;

    if (j == 0) begin : g_head
      always_comb begin
        for (int a = 0; a < 4; a++) begin
          rem_s[a] = num_r[a];
          q_s[a]   = '0;
        end
      end
      assign d_s    = den_r;
      assign ctl_s  = cp_r;
      assign pass_s = pp_r;
    end else begin : g_body
      always_comb begin
        for (int a = 0; a < 4; a++) begin
          rem_s[a] = rem_r[j-1][a];
          q_s[a]   = q_r[j-1][a];
        end
      end
      assign d_s    = d_r[j-1];
      assign ctl_s  = c_r[j-1];
      assign pass_s = p_r[j-1];
    end

    assign dsh = XW'(d_s) << K;

    always_comb begin
      for (int a = 0; a < 4; a++) begin
        ge[a] = (rem_s[a] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[j] <= '0;
      end else if (en) begin
        c_r[j] <= ctl_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j] <= d_s;
        p_r[j] <= pass_s;
        for (int a = 0; a < 4; a++) begin
          rem_r[j][a] <= ge[a] ? (rem_s[a] - dsh) : rem_s[a];
          q_r[j][a]   <= {q_s[a][QW-2:0], ge[a]};
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      q_o[a*QW +: QW] = q_r[QW-1][a];
    end
  end

  assign ctl_o  = c_r[QW-1];
  assign pass_o = p_r[QW-1];

endmodule

// ===== rtl/core/quaternion_rotate_normalize_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_normalize_core
// Rotates a stream of orientation quaternions by a held quaternion and
// renormalizes them to unit length.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one particle quaternion per word; tuser selects rotation, tlast
//           marks the last particle of a set and comes back on out_tlast.
//   out_* : one result word per input word, in order; tuser flags a product
//           of zero length (components then zero). Unselected words pass
//           through unchanged.
//   cfg_* : writes rot_w, rot_x, rot_y, rot_z by index; always ready. Write
//           only while no words are in flight. Other indexes are dropped.
// Throughput: one word per cycle while out_tready stays high.
// Pipeline: products, rounding and sums; normalizer; square root, one bit
//   per stage; divider; output register.
// Reset clears all valid bits and loads the identity rotation.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps accepting until its last stage fills; then in_tready drops.
// ----------------------------------------------------------------------------
module quaternion_rotate_normalize_core #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14,
  localparam int TDW = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [TDW-1:0]                  in_tdata,   // in_w, in_x, in_y, in_z
  input  logic                            in_tuser,   // selected
  input  logic                            in_tlast,   // in_last

  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [TDW-1:0]                  out_tdata,  // out_w, out_x, out_y, out_z
  output logic                            out_tuser,  // zero_norm
  output logic                            out_tlast,  // out_last

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qrn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COMPONENT_BITS-1:0]       cfg_data
);
  import qrn_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int RW = 2 * CB - FB + 2;
  localparam int QW = FB + 1;
  localparam int SW = ((QW > CB) ? QW : CB) + 1;
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (CB - 1);
  localparam logic [SW-1:0] LIM_POS = LIM_NEG - SW'(1);

  logic [CB-1:0]       rot_w_r, rot_x_r, rot_y_r, rot_z_r;

  logic                en;
  logic                take;
  logic                vld_last;

  qrn_ctl_t            ctl_in, ctl_h, ctl_n, ctl_s, ctl_d;
  logic [4*CB-1:0]     pass_h, pass_n, pass_s, pass_d;
  logic [4*RW-1:0]     r_h;
  logic [4*NORM_W-1:0] mag_n, mag_s;
  logic [SQ_W-1:0]     n_n;
  logic [ROOT_W-1:0]   root_s;
  logic [4*QW-1:0]     q_d;

  logic [SW-1:0]       qx [4];
  logic [SW-1:0]       sat_p [4];
  logic [SW-1:0]       sat_n [4];
  logic [SW-1:0]       neg_m [4];
  logic [CB-1:0]       res [4];

  logic                out_valid_r;
  logic [CB-1:0]       out_w_r, out_x_r, out_y_r, out_z_r;
  logic                out_zero_r;
  logic                out_last_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r <= CB'(1 << FB);
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT_W: rot_w_r <= cfg_data;
        REG_ROT_X: rot_x_r <= cfg_data;
        REG_ROT_Y: rot_y_r <= cfg_data;
        REG_ROT_Z: rot_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: advance unless the last stage is full and the output is full and not taken
  assign vld_last  = ctl_d.vld;
  assign take      = !out_valid_r || out_tready;
  assign en        = !vld_last || take;
  assign in_tready = en;

  always_comb begin
    ctl_in      = '0;
    ctl_in.vld  = in_tvalid;
    ctl_in.sel  = in_tuser;
    ctl_in.last = in_tlast;
  end

  qrn_ham #(.CB(CB), .FB(FB)) u_ham (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_in),
    .pass_i (in_tdata[4*CB-1:0]),
    .rot_i  ({rot_z_r, rot_y_r, rot_x_r, rot_w_r}),
    .ctl_o  (ctl_h),
    .pass_o (pass_h),
    .r_o    (r_h)
  );

  qrn_norm #(.CB(CB), .FB(FB)) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_h),
    .pass_i (pass_h),
    .r_i    (r_h),
    .ctl_o  (ctl_n),
    .pass_o (pass_n),
    .mag_o  (mag_n),
    .n_o    (n_n)
  );

  qrn_sqrt #(.CB(CB)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_n),
    .pass_i (pass_n),
    .mag_i  (mag_n),
    .n_i    (n_n),
    .ctl_o  (ctl_s),
    .pass_o (pass_s),
    .mag_o  (mag_s),
    .root_o (root_s)
  );

  qrn_div #(.CB(CB), .FB(FB)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_s),
    .pass_i (pass_s),
    .mag_i  (mag_s),
    .root_i (root_s),
    .ctl_o  (ctl_d),
    .pass_o (pass_d),
    .q_o    (q_d)
  );

  // sign, saturation and the pass-through and zero-length cases
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      qx[a]    = SW'(q_d[a*QW +: QW]);
      sat_p[a] = (qx[a] > LIM_POS) ? LIM_POS : qx[a];
      sat_n[a] = (qx[a] > LIM_NEG) ? LIM_NEG : qx[a];
      neg_m[a] = SW'(0) - sat_n[a];
      priority if (!ctl_d.sel) begin
        res[a] = pass_d[a*CB +: CB];
      end else if (ctl_d.zero) begin
        res[a] = '0;
      end else if (ctl_d.neg[a]) begin
        res[a] = neg_m[a][CB-1:0];
      end else begin
        res[a] = sat_p[a][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= vld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_w_r    <= res[0];
      out_x_r    <= res[1];
      out_y_r    <= res[2];
      out_z_r    <= res[3];
      out_zero_r <= ctl_d.sel & ctl_d.zero;
      out_last_r <= ctl_d.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'({out_z_r, out_y_r, out_x_r, out_w_r});
  assign out_tuser  = out_zero_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_zero_norm_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero_norm result with nonzero components");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && vld_last))
    else $error("input stalled while the pipeline could advance");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(vld_last))
    else $error("result appeared without a valid last stage");
`endif

endmodule
